// File: hdl/auwi_pkg.sv
package auwi_pkg;

   localparam int NUM_CORE_REGS = 16;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_FINISH      = 3'd1,
      ST_SPARE       = 3'd2,
      ST_RESERVED    = 3'd3,
      ST_REFUSE      = 3'd4,
      ST_UNSUPPORTED = 3'd5,
      ST_TRUNCATED   = 3'd6
   } status_type;

   // Result item kinds
   typedef enum logic {
      KIND_SUMMARY  = 1'b0,
      KIND_LOCATION = 1'b1
   } kind_type;

   localparam logic [3:0] REG_FP_THUMB = 4'd7;
   localparam logic [3:0] REG_FP_ARM   = 4'd11;
   localparam logic [3:0] REG_SP       = 4'd13;
   localparam logic [3:0] REG_LR       = 4'd14;
   localparam logic [3:0] REG_PC       = 4'd15;

   localparam logic [15:0] TRACKED_RESET = 16'hffff;
   localparam logic [31:0] ULEB_BIAS     = 32'h0000_0204;

endpackage

// File: hdl/auwi_stream_if.sv
interface auwi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] op_byte;
   logic       last_byte;

   modport source (output valid, output op_byte, output last_byte, input ready);
   modport sink   (input valid, input op_byte, input last_byte, output ready);
endinterface

interface auwi_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [2:0]  status;
   logic [3:0]  cfa_reg;
   logic signed [31:0] cfa_offset;
   logic [3:0]  ra_reg;
   logic [3:0]  reg_index;
   logic signed [31:0] reg_offset;
   logic        last_result;

   modport source (output valid, output item_kind, output status, output cfa_reg,
                   output cfa_offset, output ra_reg, output reg_index,
                   output reg_offset, output last_result, input ready);
   modport sink   (input valid, input item_kind, input status, input cfa_reg,
                   input cfa_offset, input ra_reg, input reg_index,
                   input reg_offset, input last_result, output ready);
endinterface

// File: hdl/arm_unwind_opcode_interpreter_core.sv
// A byte that moves no stack is accepted (S_IDLE), then decoded (S_DECODE).
// A byte that moves the stack then goes through S_SWEEP and S_VSP: one shared 32-bit
// adder sweeps every saved-register offset, then the stack offset.
// A last byte then adds a flush: a summary item, a scan of up to NumCoreRegs
// register slots and a clear state, plus any output stall. One byte is in work at a time.
// Reset (synchronous, active high) clears all entry state; tracked mask = 0xffff.
module arm_unwind_opcode_interpreter_core (
   input  logic        clock,
   input  logic        reset,
   auwi_req_if.sink    req_chan,
   auwi_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int NumCoreRegs = auwi_pkg::NUM_CORE_REGS;
   localparam int IdxW = $clog2(NumCoreRegs);
   localparam logic [IdxW-1:0] IdxTop = IdxW'(NumCoreRegs - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SWEEP, S_VSP, S_FLUSH_SUM, S_FLUSH_REG, S_CLEAR
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [15:0] tracked_ff;
   logic [31:0] vsp_ff, vsp_in;
   logic [15:0] popped_ff, popped_in;
   logic [31:0] offs_ff [NumCoreRegs];
   logic [7:0]  pend_op_ff, pend_op_in;
   logic        pend_vld_ff, pend_vld_in;
   logic [31:0] uleb_acc_ff, uleb_acc_in;
   logic [5:0]  uleb_sh_ff, uleb_sh_in;
   logic        pc_ff, pc_in;
   logic [3:0]  frame_ff, frame_in;
   logic        stopped_ff, stopped_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] imm_ff, imm_in;
   logic [15:0] popset_ff, popset_in;
   logic        do_add;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [4:0]  suffix_ff, suffix_in;

   logic        out_vld_ff, out_vld_in;
   logic        out_kind_ff, out_kind_in;
   logic [2:0]  out_status_ff, out_status_in;
   logic [3:0]  out_cfa_reg_ff, out_cfa_reg_in;
   logic [31:0] out_cfa_off_ff, out_cfa_off_in;
   logic [3:0]  out_ra_ff, out_ra_in;
   logic [3:0]  out_idx_ff, out_idx_in;
   logic [31:0] out_off_ff, out_off_in;
   logic        out_last_ff, out_last_in;

   logic [31:0] add_a, add_b, add_sum;
   logic [31:0] reg_add;
   logic [4:0]  cnt;
   logic [15:0] report;
   logic [15:0] higher;
   logic        out_free;
   logic [6:0]  sh_next;
   logic [31:0] acc_new;
   logic [7:0]  b;
   logic [7:0]  op;
   logic [11:0] regs12;
   logic [3:0]  n;

   function automatic logic [4:0] popcnt16(input logic [15:0] v);
      logic [4:0] c;
      c = '0;
      for (int i = 0; i < 16; i++) c = c + 5'(v[i]);
      return c;
   endfunction

   assign report   = popped_ff & tracked_ff;
   assign higher   = report >> idx_ff;
   assign out_free = !out_vld_ff || rsp_chan.ready;
   assign cnt      = suffix_ff + 5'(popset_ff[idx_ff]);

   // Pick the offset to add to the register under the sweep
   always_comb begin
      if (popped_ff[idx_ff] && tracked_ff[idx_ff]) begin
         reg_add = imm_ff;
      end else if (popset_ff[idx_ff] && tracked_ff[idx_ff]) begin
         reg_add = {25'd0, cnt, 2'b00};
      end else begin
         reg_add = '0;
      end
   end

   // Shared adder: register sweep, stack offset, and negation at flush
   always_comb begin
      unique case (state_ff)
         S_SWEEP: begin
            add_a = offs_ff[idx_ff];
            add_b = reg_add;
         end
         S_VSP: begin
            add_a = vsp_ff;
            add_b = imm_ff;
         end
         S_FLUSH_REG: begin
            add_a = ~offs_ff[idx_ff];
            add_b = 32'd1;
         end
         default: begin
            add_a = vsp_ff;
            add_b = '0;
         end
      endcase
   end
   assign add_sum = add_a + add_b;

   // Decode one byte
   always_comb begin
      b           = byte_ff;
      op          = pend_op_ff;
      regs12      = {pend_op_ff[3:0], byte_ff};
      n           = byte_ff[3:0];
      vsp_in      = vsp_ff;
      pend_op_in  = pend_op_ff;
      pend_vld_in = pend_vld_ff;
      uleb_acc_in = uleb_acc_ff;
      uleb_sh_in  = uleb_sh_ff;
      pc_in       = pc_ff;
      frame_in    = frame_ff;
      stopped_in  = stopped_ff;
      status_in   = status_ff;
      imm_in      = '0;
      popset_in   = '0;
      do_add      = 1'b0;
      sh_next     = 7'(uleb_sh_ff) + 7'd7;
      acc_new     = uleb_acc_ff;
      if (uleb_sh_ff < 6'd32) begin
         acc_new = uleb_acc_ff | ({25'd0, b[6:0]} << uleb_sh_ff[4:0]);
      end
      if (!stopped_ff && pend_vld_ff) begin
         pend_vld_in = 1'b0;
         if (op[7:4] == 4'h8) begin
            if (regs12 == '0) begin
               status_in  = auwi_pkg::ST_REFUSE;
               stopped_in = 1'b1;
            end else begin
               popset_in = {regs12, 4'd0};
               if (regs12[11]) pc_in = 1'b1;
               imm_in = {25'd0, popcnt16({regs12, 4'd0}), 2'b00};
               do_add = 1'b1;
            end
         end else if (op == 8'hb1 || op == 8'hc7) begin
            if (b == 8'd0 || b[7:4] != 4'd0) begin
               status_in  = auwi_pkg::ST_SPARE;
               stopped_in = 1'b1;
            end else begin
               imm_in = {25'd0, popcnt16({12'd0, b[3:0]}), 2'b00};
               do_add = 1'b1;
            end
         end else if (op == 8'hb2) begin
            uleb_sh_in = (sh_next > 7'd63) ? 6'd63 : sh_next[5:0];
            if (b[7]) begin
               pend_vld_in = 1'b1;
               uleb_acc_in = acc_new;
            end else begin
               imm_in      = auwi_pkg::ULEB_BIAS + {acc_new[29:0], 2'b00};
               do_add      = 1'b1;
               uleb_acc_in = '0;
               uleb_sh_in  = '0;
            end
         end else if (op == 8'hb3) begin
            imm_in = {24'd0, 5'(b[3:0]) + 5'd1, 3'b000} + 32'd4;
            do_add = 1'b1;
         end else begin
            imm_in = {24'd0, 5'(b[3:0]) + 5'd1, 3'b000};
            do_add = 1'b1;
         end
      end else if (!stopped_ff) begin
         if (b < 8'h40) begin
            imm_in = {24'd0, b[5:0], 2'b00} + 32'd4;
            do_add = 1'b1;
         end else if (b < 8'h80) begin
            imm_in = 32'd0 - ({24'd0, b[5:0], 2'b00} + 32'd4);
            do_add = 1'b1;
         end else if (b < 8'h90 || b == 8'hb1 || b == 8'hb2 || b == 8'hb3 ||
                      b == 8'hc6 || b == 8'hc7 || b == 8'hc8 || b == 8'hc9) begin
            pend_op_in  = b;
            pend_vld_in = 1'b1;
            uleb_acc_in = '0;
            uleb_sh_in  = '0;
         end else if (b < 8'ha0) begin
            if (n == auwi_pkg::REG_SP || n == auwi_pkg::REG_PC) begin
               status_in  = auwi_pkg::ST_RESERVED;
               stopped_in = 1'b1;
            end else if (n != auwi_pkg::REG_FP_THUMB && n != auwi_pkg::REG_FP_ARM) begin
               status_in  = auwi_pkg::ST_UNSUPPORTED;
               stopped_in = 1'b1;
            end else begin
               if (popped_ff == '0) vsp_in = '0;
               frame_in = n;
            end
         end else if (b < 8'hb0) begin
            for (int r = 4; r < 12; r++) begin
               popset_in[r] = (r <= 4 + int'(b[2:0]));
            end
            popset_in[auwi_pkg::REG_LR] = b[3];
            imm_in = {25'd0, popcnt16(popset_in), 2'b00};
            do_add = 1'b1;
         end else if (b == 8'hb0) begin
            status_in  = auwi_pkg::ST_FINISH;
            stopped_in = 1'b1;
         end else if (b < 8'hb8) begin
            status_in  = auwi_pkg::ST_SPARE;
            stopped_in = 1'b1;
         end else if (b < 8'hc0) begin
            imm_in = {24'd0, 5'(b[2:0]) + 5'd1, 3'b000} + 32'd4;
            do_add = 1'b1;
         end else if ((b & 8'hc8) == 8'hc8) begin
            status_in  = auwi_pkg::ST_SPARE;
            stopped_in = 1'b1;
         end else if ((b & 8'hf8) == 8'hc0 || (b & 8'hf8) == 8'hd0) begin
            imm_in = {24'd0, 5'(b[2:0]) + 5'd1, 3'b000};
            do_add = 1'b1;
         end else begin
            status_in  = auwi_pkg::ST_SPARE;
            stopped_in = 1'b1;
         end
      end
   end

   // Sequencer and output register next values
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      suffix_in      = suffix_ff;
      popped_in      = popped_ff;
      out_vld_in     = out_vld_ff && !rsp_chan.ready;
      out_kind_in    = out_kind_ff;
      out_status_in  = out_status_ff;
      out_cfa_reg_in = out_cfa_reg_ff;
      out_cfa_off_in = out_cfa_off_ff;
      out_ra_in      = out_ra_ff;
      out_idx_in     = out_idx_ff;
      out_off_in     = out_off_ff;
      out_last_in    = out_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (do_add) begin
               state_in  = S_SWEEP;
               idx_in    = IdxTop;
               suffix_in = '0;
            end else if (last_ff) begin
               state_in = S_FLUSH_SUM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            suffix_in = cnt;
            if (idx_ff == '0) begin
               state_in = S_VSP;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         S_VSP: begin
            popped_in = popped_ff | popset_ff;
            state_in  = last_ff ? S_FLUSH_SUM : S_IDLE;
         end
         S_FLUSH_SUM: begin
            if (out_free) begin
               out_vld_in     = 1'b1;
               out_kind_in    = auwi_pkg::KIND_SUMMARY;
               out_status_in  = (!stopped_ff && pend_vld_ff) ?
                                auwi_pkg::ST_TRUNCATED : status_ff;
               out_cfa_reg_in = (frame_ff == '0) ? auwi_pkg::REG_SP : frame_ff;
               out_cfa_off_in = vsp_ff;
               out_ra_in      = pc_ff ? auwi_pkg::REG_PC : auwi_pkg::REG_LR;
               out_idx_in     = '0;
               out_off_in     = '0;
               out_last_in    = (report == '0);
               idx_in         = '0;
               state_in       = (report == '0) ? S_CLEAR : S_FLUSH_REG;
            end
         end
         S_FLUSH_REG: begin
            if (report[idx_ff]) begin
               if (out_free) begin
                  out_vld_in     = 1'b1;
                  out_kind_in    = auwi_pkg::KIND_LOCATION;
                  out_status_in  = auwi_pkg::ST_OK;
                  out_cfa_reg_in = '0;
                  out_cfa_off_in = '0;
                  out_ra_in      = '0;
                  out_idx_in     = 4'(idx_ff);
                  out_off_in     = add_sum;
                  out_last_in    = (higher == 16'd1);
                  if (higher == 16'd1 || idx_ff == IdxTop) begin
                     state_in = S_CLEAR;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end else if (idx_ff == IdxTop) begin
               state_in = S_CLEAR;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CLEAR: begin
            popped_in = '0;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == S_IDLE);

   // Hold state, offsets and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         tracked_ff  <= auwi_pkg::TRACKED_RESET;
         vsp_ff      <= '0;
         popped_ff   <= '0;
         pend_op_ff  <= '0;
         pend_vld_ff <= 1'b0;
         uleb_acc_ff <= '0;
         uleb_sh_ff  <= '0;
         pc_ff       <= 1'b0;
         frame_ff    <= '0;
         stopped_ff  <= 1'b0;
         status_ff   <= auwi_pkg::ST_OK;
         out_vld_ff  <= 1'b0;
         idx_ff      <= '0;
         suffix_ff   <= '0;
         for (int r = 0; r < NumCoreRegs; r++) offs_ff[r] <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         suffix_ff  <= suffix_in;
         popped_ff  <= popped_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) tracked_ff <= csr_wr_data;
         if (state_ff == S_IDLE && req_chan.valid) begin
            byte_ff <= req_chan.op_byte;
            last_ff <= req_chan.last_byte;
         end
         if (state_ff == S_DECODE) begin
            vsp_ff      <= vsp_in;
            pend_op_ff  <= pend_op_in;
            pend_vld_ff <= pend_vld_in;
            uleb_acc_ff <= uleb_acc_in;
            uleb_sh_ff  <= uleb_sh_in;
            pc_ff       <= pc_in;
            frame_ff    <= frame_in;
            stopped_ff  <= stopped_in;
            status_ff   <= status_in;
            imm_ff      <= imm_in;
            popset_ff   <= popset_in;
         end
         if (state_ff == S_SWEEP) offs_ff[idx_ff] <= add_sum;
         if (state_ff == S_VSP) vsp_ff <= add_sum;
         if (state_ff == S_CLEAR) begin
            vsp_ff      <= '0;
            pend_op_ff  <= '0;
            pend_vld_ff <= 1'b0;
            uleb_acc_ff <= '0;
            uleb_sh_ff  <= '0;
            pc_ff       <= 1'b0;
            frame_ff    <= '0;
            stopped_ff  <= 1'b0;
            status_ff   <= auwi_pkg::ST_OK;
            for (int r = 0; r < NumCoreRegs; r++) offs_ff[r] <= '0;
         end
      end
      out_kind_ff    <= out_kind_in;
      out_status_ff  <= out_status_in;
      out_cfa_reg_ff <= out_cfa_reg_in;
      out_cfa_off_ff <= out_cfa_off_in;
      out_ra_ff      <= out_ra_in;
      out_idx_ff     <= out_idx_in;
      out_off_ff     <= out_off_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.item_kind   = out_kind_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.cfa_reg     = out_cfa_reg_ff;
   assign rsp_chan.cfa_offset  = out_cfa_off_ff;
   assign rsp_chan.ra_reg      = out_ra_ff;
   assign rsp_chan.reg_index   = out_idx_ff;
   assign rsp_chan.reg_offset  = out_off_ff;
   assign rsp_chan.last_result = out_last_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input taken while a byte is in work");

   a_clear_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |=> (popped_ff == '0 && vsp_ff == '0 && !stopped_ff))
      else $error("entry state not cleared after flush");

   a_summary_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH_SUM && out_free) |=>
      (out_vld_ff && out_kind_ff == auwi_pkg::KIND_SUMMARY))
      else $error("summary item not presented");
`endif

endmodule
